/* rtl/rrexp_pkg.sv */
// Shared types and constants of the range-reduced rational exponential core.
// No dependencies; every other file of the core imports this package.
package rrexp_pkg;

    localparam logic [63:0] INV_LN2_Q60 = 64'h1715_4765_2B82_FE17;
    localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
    localparam logic [63:0] HALF32      = 64'h0000_0000_8000_0000;
    localparam int          EXP_W       = 17;
    localparam int          EXP_MAX     = 65535;
    localparam int          EXP_MIN_MAG = 65536;
    localparam int          QUEUE_DEPTH = 4;

    // One reduced argument handed from the front to the back.
    typedef struct packed {
        logic [31:0]              w;
        logic                     uneg;
        logic signed [EXP_W-1:0]  expo;
    } rrexp_item_t;

    // Side data carried through the dividers.
    typedef struct packed {
        logic [31:0]              umag;
        logic                     uneg;
        logic signed [EXP_W-1:0]  expo;
    } rrexp_side_t;

endpackage

/* rtl/range_reduced_rational_exponential_core.sv */
// Top level of the range-reduced rational exponential core.
// Depends on rrexp_pkg, rrexp_front, rrexp_queue and rrexp_back.
//
// The core computes exp(x) for a signed fixed-point argument x (Q15.16 by
// default) and returns it as an unsigned mantissa in [~0.707, ~1.414]
// (Q1.30 by default) and a signed binary exponent m, so the value is
// mantissa * 2^m and never overflows. The argument is reduced as
// m = round(x/ln2) with halves away from zero and u = (x/ln2 - m)*ln2, and
// exp(u) is evaluated with a Pade rational form. While nothing stalls, one
// beat is accepted per clock cycle and one result beat is delivered per
// cycle; there is no state between beats. A beat passes through the
// five-stage front, the four-entry queue, the polynomial stages and two
// pipelined dividers (29 and 31 stages, one quotient bit each) before its
// result is shown on m_valid.
// The front stalls only when the queue is full, and the back stalls only
// when its output register holds an untaken result.
module range_reduced_rational_exponential_core import rrexp_pkg::*; #(
    parameter int ARG_FRAC_BITS  = 16,
    parameter int MANT_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_arg_fixed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_mantissa,
    output logic signed [EXP_W-1:0] m_pow2_exponent
);
    logic        push, pop, q_full, q_empty;
    rrexp_item_t push_item, pop_item;

    // The front reduces the argument and pushes exponent and remainder.
    rrexp_front #(.ARG_FRAC_BITS(ARG_FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_arg_fixed(s_arg_fixed),
        .push(push), .q_full(q_full), .push_item(push_item)
    );

    // The queue lets the front and back stall independently.
    rrexp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_item(push_item),
        .pop(pop), .pop_item(pop_item),
        .full(q_full), .empty(q_empty)
    );

    // The back evaluates the rational form and the final quotient.
    rrexp_back #(.MANT_FRAC_BITS(MANT_FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .pop(pop), .pop_item(pop_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_mantissa(m_mantissa), .m_pow2_exponent(m_pow2_exponent)
    );
endmodule

/* rtl/rrexp_front.sv */
// Front part: accepts arguments, takes magnitude, multiplies by 1/ln2 and
// splits into exponent and remainder. Depends on rrexp_pkg.
module rrexp_front import rrexp_pkg::*; #(
    parameter int ARG_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_arg_fixed,
    output logic        push,
    input  logic        q_full,
    output rrexp_item_t push_item
);
    localparam int ZF = ARG_FRAC_BITS + 30;
    localparam int WS = ZF - 32;
    localparam logic [33:0] CHI = 34'(INV_LN2_Q60 >> 30);
    localparam logic [29:0] CLO = INV_LN2_Q60[29:0];

    logic        en;
    logic [4:0]  v_reg;
    logic [31:0] a_reg;
    logic [3:0]  neg_reg;
    logic [63:0] phi_reg, plo_reg, zmag_reg, mmag_reg, rmag_reg;
    logic        rneg_reg;
    rrexp_item_t item_reg;
    logic [63:0] mmag_c, base_c, wr_c;
    logic signed [EXP_W-1:0] e_c;

    assign en      = !(v_reg[4] && q_full);
    assign s_ready = en;
    assign push    = v_reg[4] && !q_full;
    assign push_item = item_reg;

    always_comb begin
        mmag_c = (zmag_reg + (64'd1 << (ZF - 1))) >> ZF;
        base_c = mmag_c << ZF;
        wr_c   = (rmag_reg + (64'd1 << (WS - 1))) >> WS;
        if (neg_reg[3]) begin
            e_c = (mmag_reg > 64'(EXP_MIN_MAG)) ? -EXP_W'(EXP_MIN_MAG)
                                                : -EXP_W'(mmag_reg);
        end else begin
            e_c = (mmag_reg > 64'(EXP_MAX)) ? EXP_W'(EXP_MAX) : EXP_W'(mmag_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= s_arg_fixed[31] ? (32'd0 - s_arg_fixed) : s_arg_fixed;
            neg_reg  <= {neg_reg[2:0], s_arg_fixed[31]};
            phi_reg  <= 64'(a_reg) * 64'(CHI);
            plo_reg  <= 64'(a_reg) * 64'(CLO);
            zmag_reg <= phi_reg + (plo_reg >> 30);
            mmag_reg <= mmag_c;
            if (base_c >= zmag_reg) begin
                rmag_reg <= base_c - zmag_reg;
                rneg_reg <= 1'b1;
            end else begin
                rmag_reg <= zmag_reg - base_c;
                rneg_reg <= 1'b0;
            end
            item_reg.w    <= wr_c[31:0];
            item_reg.uneg <= neg_reg[3] ^ rneg_reg;
            item_reg.expo <= e_c;
        end
    end
endmodule

/* rtl/rrexp_queue.sv */
// Short queue of reduced items between the front and the back.
// Depends on rrexp_pkg.
module rrexp_queue import rrexp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  rrexp_item_t push_item,
    input  logic        pop,
    output rrexp_item_t pop_item,
    output logic        full,
    output logic        empty
);
    localparam int AW = $clog2(QUEUE_DEPTH);

    rrexp_item_t      mem [QUEUE_DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign full     = cnt_reg == (AW+1)'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_item = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop) else $error("pop from empty queue");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow push");
endmodule

/* rtl/rrexp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on rrexp_pkg.
module rrexp_div import rrexp_pkg::*; #(
    parameter int DENW = 34,
    parameter int QW   = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       in_num,
    input  logic [DENW-1:0]   in_den,
    input  rrexp_side_t       in_side,
    output logic              out_valid,
    output logic [QW-1:0]     out_quo,
    output rrexp_side_t       out_side
);
    logic [63:0]     rem_reg  [QW+1];
    logic [QW-1:0]   quo_reg  [QW+1];
    logic [DENW-1:0] den_reg  [QW+1];
    rrexp_side_t     side_reg [QW+1];
    logic [QW:0]     v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= in_num;
            quo_reg[0]  <= '0;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [63:0] dsh;
        assign dsh = 64'(den_reg[k]) << B;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[k] >= dsh) begin
                    rem_reg[k+1] <= rem_reg[k] - dsh;
                    quo_reg[k+1] <= quo_reg[k] | (QW'(1) << B);
                end else begin
                    rem_reg[k+1] <= rem_reg[k];
                    quo_reg[k+1] <= quo_reg[k];
                end
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_quo   = quo_reg[QW];
    assign out_side  = side_reg[QW];
endmodule

/* rtl/rrexp_back.sv */
// Back part: evaluates the rational approximant on the reduced argument and
// forms the mantissa. Depends on rrexp_pkg and rrexp_div.
module rrexp_back import rrexp_pkg::*; #(
    parameter int MANT_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    output logic        pop,
    input  rrexp_item_t pop_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_mantissa,
    output logic signed [EXP_W-1:0] m_pow2_exponent
);
    logic        en;
    logic [6:0]  v_reg;
    logic [63:0] p1_reg, sq_reg, vv_reg, np_reg;
    logic [31:0] umag_reg [6:1];
    logic [6:0]  uneg_reg;
    logic signed [EXP_W-1:0] e_reg [6:0];
    logic [31:0] v_reg4, v_reg5, v_reg6;
    logic [39:0] t28_reg, t420_reg;
    logic [33:0] pnum_reg, pden_reg, pden7_reg;
    logic [63:0] v2_c;
    rrexp_side_t s1_side, d1_side, s2_side, d2_side;
    logic        d1_valid, d2_valid, s_valid_reg;
    logic [28:0] q_quo;
    logic [33:0] nu_reg, de_reg;
    logic [30:0] mant_quo;
    logic        mv_reg;
    logic [30:0] mant_reg;
    logic signed [EXP_W-1:0] expo_reg;

    assign en  = !mv_reg || m_ready;
    assign pop = en && !q_empty;
    assign v2_c = (vv_reg + HALF32) >> 32;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], !q_empty};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg      <= 64'(pop_item.w) * 64'(LN2_Q32);
            uneg_reg[0] <= pop_item.uneg;
            e_reg[0]    <= pop_item.expo;
            umag_reg[1] <= 32'((p1_reg + HALF32) >> 32);
            sq_reg      <= 64'(umag_reg[1]) * 64'(umag_reg[1]);
            v_reg4      <= 32'((sq_reg + HALF32) >> 32);
            vv_reg      <= 64'(v_reg4) * 64'(v_reg4);
            t28_reg     <= 40'(v_reg4) * 40'd28;
            t420_reg    <= 40'(v_reg4) * 40'd420;
            v_reg5      <= v_reg4;
            pnum_reg    <= (34'd2520 << 20) + 34'((t28_reg + 40'd2048) >> 12);
            pden_reg    <= (34'd15120 << 20) + 34'((t420_reg + 40'd2048) >> 12)
                         + 34'((v2_c + 64'd2048) >> 12);
            v_reg6      <= v_reg5;
            np_reg      <= 64'(v_reg6) * 64'(pnum_reg);
            pden7_reg   <= pden_reg;
            for (int i = 2; i <= 6; i++) umag_reg[i] <= umag_reg[i-1];
            for (int i = 1; i <= 6; i++) begin
                uneg_reg[i] <= uneg_reg[i-1];
                e_reg[i]    <= e_reg[i-1];
            end
        end
    end

    assign s1_side = '{umag: umag_reg[6], uneg: uneg_reg[6], expo: e_reg[6]};

    rrexp_div #(.DENW(34), .QW(29)) u_div_q (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_reg[6]), .in_num(np_reg + 64'(pden7_reg >> 1)),
        .in_den(pden7_reg), .in_side(s1_side),
        .out_valid(d1_valid), .out_quo(q_quo), .out_side(d1_side)
    );

    // s = 2 + q; numerator and denominator of the final quotient.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg <= 1'b0;
        end else if (en) begin
            s_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (d1_side.uneg) begin
                nu_reg <= (34'd2 << 32) + 34'(q_quo) - 34'(d1_side.umag);
                de_reg <= (34'd2 << 32) + 34'(q_quo) + 34'(d1_side.umag);
            end else begin
                nu_reg <= (34'd2 << 32) + 34'(q_quo) + 34'(d1_side.umag);
                de_reg <= (34'd2 << 32) + 34'(q_quo) - 34'(d1_side.umag);
            end
            s2_side <= d1_side;
        end
    end

    // The mantissa stays below 2^31, so 31 quotient bits suffice and the
    // shifted divisor never leaves the 64-bit remainder.
    rrexp_div #(.DENW(34), .QW(31)) u_div_m (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid_reg),
        .in_num((64'(nu_reg) << MANT_FRAC_BITS) + 64'(de_reg >> 1)),
        .in_den(de_reg), .in_side(s2_side),
        .out_valid(d2_valid), .out_quo(mant_quo), .out_side(d2_side)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (en) begin
            mv_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mant_reg <= mant_quo;
            expo_reg <= d2_side.expo;
        end
    end

    assign m_valid         = mv_reg;
    assign m_mantissa      = mant_reg;
    assign m_pow2_exponent = expo_reg;
endmodule
